// ----- src/smx_pkg.sv -----
// Package: constants, opcodes and types shared by the stack executor modules.
package smx_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int SP_W = 11;
    localparam int ADDR_W = 10;
    localparam int WORD_W = 256;
    localparam int LIMB_W = 64;

    localparam logic [63:0] GAS_RESET = 64'd30000000;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_STOP = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_UNDER = 3'd3;
    localparam logic [2:0] ST_OVER = 3'd4;
    localparam logic [2:0] ST_SELFD = 3'd5;

    localparam logic [7:0] OP_STOP = 8'h00;
    localparam logic [7:0] OP_ADD = 8'h01;
    localparam logic [7:0] OP_MUL = 8'h02;
    localparam logic [7:0] OP_SUB = 8'h03;
    localparam logic [7:0] OP_DIV = 8'h04;
    localparam logic [7:0] OP_MOD = 8'h06;
    localparam logic [7:0] OP_ADDMOD = 8'h08;
    localparam logic [7:0] OP_MULMOD = 8'h09;
    localparam logic [7:0] OP_LT = 8'h10;
    localparam logic [7:0] OP_GT = 8'h11;
    localparam logic [7:0] OP_EQ = 8'h14;
    localparam logic [7:0] OP_ISZERO = 8'h15;
    localparam logic [7:0] OP_AND = 8'h16;
    localparam logic [7:0] OP_OR = 8'h17;
    localparam logic [7:0] OP_XOR = 8'h18;
    localparam logic [7:0] OP_NOT = 8'h19;
    localparam logic [7:0] OP_SHL = 8'h1B;
    localparam logic [7:0] OP_SHR = 8'h1C;
    localparam logic [7:0] OP_GASLIMIT = 8'h45;
    localparam logic [7:0] OP_POP = 8'h50;
    localparam logic [7:0] OP_PC = 8'h58;
    localparam logic [7:0] OP_PUSH_LO = 8'h60;
    localparam logic [7:0] OP_PUSH_HI = 8'h7F;
    localparam logic [7:0] OP_DUP_LO = 8'h80;
    localparam logic [7:0] OP_DUP_HI = 8'h8F;
    localparam logic [7:0] OP_SWAP_LO = 8'h90;
    localparam logic [7:0] OP_SWAP_HI = 8'h9F;
    localparam logic [7:0] OP_SELFD = 8'hFF;

    typedef struct packed {
        logic [7:0]  func;
        logic [63:0] imm_limb0;
        logic [63:0] imm_limb1;
        logic [63:0] imm_limb2;
        logic [63:0] imm_limb3;
        logic [31:0] instr_addr;
    } instr_t;

    typedef struct packed {
        logic [63:0]     top_limb0;
        logic [63:0]     top_limb1;
        logic [63:0]     top_limb2;
        logic [63:0]     top_limb3;
        logic [SP_W-1:0] stack_depth;
        logic [2:0]      status;
    } result_t;

    // Request to the shared unit.
    typedef struct packed {
        logic         start;
        logic [7:0]   op;
        logic [255:0] a;
        logic [255:0] b;
        logic [255:0] c;
    } alu_req_t;

    typedef struct packed {
        logic         done;
        logic [255:0] r;
    } alu_rsp_t;

endpackage

// ----- src/smx_if.sv -----
// Valid/ready channel interface carrying one payload type per instance.
interface smx_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/stack_machine_256bit_executor.sv -----
// Top level: decode, stack sequencer over four limb RAMs, and the shared unit.
// ALU ops go through the shared unit and other ops bypass it; MULMOD runs 64 multiply steps
//   and, for a nonzero modulus, 512 divide steps.
// Throughput: one instruction at a time; ready returns the cycle after the result beat.
// Reset: stack pointer and halt state clear, gas limit returns to 30000000;
//   stack RAM contents stay undefined.
module stack_machine_256bit_executor (
    input logic clk,
    input logic rst_n,
    smx_if.sink   in_ch,
    smx_if.sink   cfg_ch,
    smx_if.source out_ch
);
    import smx_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD_A = 4'd1;
    localparam logic [3:0] S_RD_B = 4'd2;
    localparam logic [3:0] S_RD_C = 4'd3;
    localparam logic [3:0] S_RD_N = 4'd4;
    localparam logic [3:0] S_ALU = 4'd5;
    localparam logic [3:0] S_WAIT = 4'd6;
    localparam logic [3:0] S_WR1 = 4'd7;
    localparam logic [3:0] S_WR2 = 4'd8;
    localparam logic [3:0] S_TOP = 4'd9;
    localparam logic [3:0] S_TOPW = 4'd10;
    localparam logic [3:0] S_OUT = 4'd11;

    logic [3:0]      state_reg, state_next;
    instr_t          ins_reg;
    logic [SP_W-1:0] sp_reg;
    logic            halted_reg;
    logic [2:0]      hcode_reg;
    logic [2:0]      status_reg;
    logic [63:0]     gas_reg;
    logic [255:0]    a_reg, b_reg, c_reg, n_reg, r_reg;
    logic [SP_W-1:0] pops_reg;
    logic            push_reg;
    logic            swap_reg;
    logic            alu_op_reg;
    logic [SP_W-1:0] n_idx_reg;
    result_t         res_reg;

    logic [ADDR_W-1:0] addr;
    logic              we;
    logic [255:0]      wdata, rdata;
    alu_req_t          req;
    alu_rsp_t          rsp;

    logic [7:0]      op;
    logic [SP_W-1:0] need_d, pops_d;
    logic            push_d, swap_d, alu_d, valid_d;
    logic            exec_d;
    logic [2:0]      st_d;
    logic [255:0]    imm_w, push_mask;
    logic [8:0]      push_bits;
    logic [SP_W:0]   newsp;

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_limb
            smx_ram #(.WIDTH(LIMB_W), .DEPTH(STACK_DEPTH)) u_ram (
                .clk  (clk),
                .we   (we),
                .addr (addr),
                .wdata(wdata[64*g +: 64]),
                .rdata(rdata[64*g +: 64])
            );
        end
    endgenerate

    smx_alu u_alu (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    assign op = in_ch.data.func;
    assign imm_w = {in_ch.data.imm_limb3, in_ch.data.imm_limb2,
                    in_ch.data.imm_limb1, in_ch.data.imm_limb0};
    assign push_bits = {1'b0, op - 8'd95} << 3;
    assign push_mask = (push_bits[8]) ? '1 : ~({256{1'b1}} << push_bits[7:0]);
    assign exec_d = !halted_reg && st_d == ST_OK && valid_d;

    always_comb
    begin
        need_d = '0;
        pops_d = '0;
        push_d = 1'b0;
        swap_d = 1'b0;
        alu_d = 1'b0;
        valid_d = 1'b1;
        st_d = ST_OK;
        priority case (op)
            OP_ADD, OP_MUL, OP_SUB, OP_DIV, OP_MOD, OP_LT, OP_GT, OP_EQ,
            OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR:
            begin
                need_d = 11'd2; pops_d = 11'd2; push_d = 1'b1; alu_d = 1'b1;
            end
            OP_ADDMOD, OP_MULMOD:
            begin
                need_d = 11'd3; pops_d = 11'd3; push_d = 1'b1; alu_d = 1'b1;
            end
            OP_ISZERO, OP_NOT:
            begin
                need_d = 11'd1; pops_d = 11'd1; push_d = 1'b1; alu_d = 1'b1;
            end
            OP_POP:
            begin
                need_d = 11'd1; pops_d = 11'd1;
            end
            OP_GASLIMIT, OP_PC: push_d = 1'b1;
            OP_STOP: st_d = ST_STOP;
            OP_SELFD: st_d = ST_SELFD;
            default:
            begin
                if (op >= OP_PUSH_LO && op <= OP_PUSH_HI)
                begin
                    push_d = 1'b1;
                end
                else if (op >= OP_DUP_LO && op <= OP_DUP_HI)
                begin
                    need_d = {3'd0, op - 8'd127}; push_d = 1'b1;
                end
                else if (op >= OP_SWAP_LO && op <= OP_SWAP_HI)
                begin
                    need_d = {3'd0, op - 8'd142}; swap_d = 1'b1;
                end
                else
                begin
                    st_d = ST_INVALID;
                    valid_d = 1'b0;
                end
            end
        endcase
        newsp = {1'b0, sp_reg} - {1'b0, pops_d} + {11'd0, push_d};
        if (st_d == ST_OK && sp_reg < need_d)
        begin
            st_d = ST_UNDER;
        end
        else if (st_d == ST_OK && newsp > (SP_W+1)'(STACK_DEPTH))
        begin
            st_d = ST_OVER;
        end
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data = res_reg;

    always_comb
    begin
        state_next = state_reg;
        addr = '0;
        we = 1'b0;
        wdata = r_reg;
        req = '0;
        req.op = ins_reg.func;
        req.a = a_reg;
        req.b = b_reg;
        req.c = c_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = S_RD_A;
                end
            end
            S_RD_A:
            begin
                addr = ADDR_W'(sp_reg - 11'd1);
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                addr = ADDR_W'(sp_reg - 11'd2);
                state_next = S_RD_C;
            end
            S_RD_C:
            begin
                addr = ADDR_W'(sp_reg - 11'd3);
                state_next = S_RD_N;
            end
            S_RD_N:
            begin
                addr = ADDR_W'(n_idx_reg);
                state_next = S_ALU;
            end
            S_ALU:
            begin
                req.start = alu_op_reg;
                state_next = alu_op_reg ? S_WAIT : S_WR1;
            end
            S_WAIT:
            begin
                if (rsp.done)
                begin
                    state_next = S_WR1;
                end
            end
            S_WR1:
            begin
                we = push_reg || swap_reg;
                addr = ADDR_W'(swap_reg ? (sp_reg - 11'd1) : (sp_reg - pops_reg));
                wdata = swap_reg ? n_reg : r_reg;
                state_next = S_WR2;
            end
            S_WR2:
            begin
                we = swap_reg;
                addr = ADDR_W'(n_idx_reg);
                wdata = a_reg;
                state_next = S_TOP;
            end
            S_TOP:
            begin
                addr = ADDR_W'(sp_reg - 11'd1);
                state_next = S_TOPW;
            end
            S_TOPW:
            begin
                addr = ADDR_W'(sp_reg - 11'd1);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg <= '0;
            halted_reg <= 1'b0;
            hcode_reg <= ST_OK;
            gas_reg <= GAS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                gas_reg <= cfg_ch.data;
            end
            if (state_reg == S_IDLE && in_ch.valid)
            begin
                if (!halted_reg && st_d != ST_OK)
                begin
                    halted_reg <= 1'b1;
                    hcode_reg <= st_d;
                end
            end
            if (state_reg == S_WR2)
            begin
                sp_reg <= SP_W'(sp_reg - pops_reg + {10'd0, push_reg});
            end
        end
    end

    // Capture payload and operands; hold the stack on a skipped step.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                ins_reg <= in_ch.data;
                n_idx_reg <= sp_reg - need_d;
                status_reg <= halted_reg ? hcode_reg : st_d;
                pops_reg <= exec_d ? pops_d : '0;
                push_reg <= exec_d && push_d;
                swap_reg <= exec_d && swap_d;
                alu_op_reg <= exec_d && alu_d;
                if (op == OP_GASLIMIT)
                begin
                    r_reg <= {192'd0, gas_reg};
                end
                else if (op == OP_PC)
                begin
                    r_reg <= {224'd0, in_ch.data.instr_addr};
                end
                else if (op >= OP_PUSH_LO && op <= OP_PUSH_HI)
                begin
                    r_reg <= imm_w & push_mask;
                end
                else
                begin
                    r_reg <= '0;
                end
            end
            S_RD_B: a_reg <= rdata;
            S_RD_C: b_reg <= rdata;
            S_RD_N: c_reg <= rdata;
            S_ALU:
            begin
                n_reg <= rdata;
                if (!alu_op_reg && pops_reg == '0 && push_reg && !swap_reg
                    && ins_reg.func >= OP_DUP_LO && ins_reg.func <= OP_DUP_HI)
                begin
                    r_reg <= rdata;
                end
            end
            S_WAIT:
            begin
                if (rsp.done)
                begin
                    r_reg <= rsp.r;
                end
            end
            S_OUT:
            begin
            end
            S_TOPW:
            begin
                res_reg.top_limb0 <= (sp_reg == '0) ? '0 : rdata[63:0];
                res_reg.top_limb1 <= (sp_reg == '0) ? '0 : rdata[127:64];
                res_reg.top_limb2 <= (sp_reg == '0) ? '0 : rdata[191:128];
                res_reg.top_limb3 <= (sp_reg == '0) ? '0 : rdata[255:192];
                res_reg.stack_depth <= sp_reg;
                res_reg.status <= status_reg;
            end
            default:
            begin
            end
        endcase
    end

    property p_ready_idle;
        @(posedge clk) disable iff (!rst_n) in_ch.ready |-> !out_ch.valid;
    endproperty
    assert property (p_ready_idle) else $error("input ready while result pending");

    property p_sp_range;
        @(posedge clk) disable iff (!rst_n) sp_reg <= SP_W'(STACK_DEPTH);
    endproperty
    assert property (p_sp_range) else $error("stack pointer beyond depth");

    property p_halt_sticky;
        @(posedge clk) disable iff (!rst_n) halted_reg |=> halted_reg;
    endproperty
    assert property (p_halt_sticky) else $error("halt cleared without reset");

    property p_halt_frozen;
        @(posedge clk) disable iff (!rst_n) halted_reg && state_reg == S_IDLE
            |=> $stable(sp_reg);
    endproperty
    assert property (p_halt_frozen) else $error("stack moved while halted");

endmodule

// ----- src/smx_ram.sv -----
// Generic single-port RAM with registered read.
module smx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- src/smx_alu.sv -----
// Shared iterative arithmetic unit: 32x32 multiply steps, bit-serial divide, shifts.
module smx_alu (
    input  logic                clk,
    input  logic                rst_n,
    input  smx_pkg::alu_req_t   req,
    output smx_pkg::alu_rsp_t   rsp
);
    import smx_pkg::*;

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL = 3'd1;
    localparam logic [2:0] A_DIV = 3'd2;
    localparam logic [2:0] A_DONE = 3'd3;
    localparam logic [2:0] A_ADD = 3'd4;

    logic [2:0]   state_reg, state_next;
    logic [7:0]   op_reg;
    logic [255:0] a_reg, b_reg, c_reg;
    logic [511:0] num_reg;
    logic [511:0] prod_reg;
    logic [5:0]   mstep_reg;
    logic [9:0]   cnt_reg;
    logic [255:0] rem_reg;
    logic [255:0] quo_reg;
    logic [255:0] res_reg;
    logic         rem_out;

    logic [31:0]  ma, mb;
    logic [63:0]  mp;
    logic [2:0]   mi, mj;
    logic [511:0] prod_sum;
    logic [256:0] rsh;
    logic [256:0] rsub;
    logic         ge;
    logic [256:0] sum257;
    logic [255:0] shl_v, shr_v;
    logic         big_amt;
    logic [7:0]   amt;

    assign mi = mstep_reg[5:3];
    assign mj = mstep_reg[2:0];
    assign ma = a_reg[32*mi +: 32];
    assign mb = b_reg[32*mj +: 32];
    assign mp = ma * mb;
    assign prod_sum = prod_reg + ({448'd0, mp} << (32 * (mi + mj)));

    assign rsh = {rem_reg, num_reg[511]};
    assign rsub = rsh - {1'b0, c_reg};
    assign ge = !rsub[256];
    assign sum257 = {1'b0, a_reg} + {1'b0, b_reg};
    assign big_amt = |a_reg[255:8];
    assign amt = a_reg[7:0];
    assign shl_v = big_amt ? '0 : (b_reg << amt);
    assign shr_v = big_amt ? '0 : (b_reg >> amt);
    assign rem_out = 1'b0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    state_next = A_ADD;
                end
            end
            A_ADD:
            begin
                if (op_reg == OP_MUL || op_reg == OP_MULMOD)
                begin
                    state_next = A_MUL;
                end
                else if ((op_reg == OP_DIV || op_reg == OP_MOD || op_reg == OP_ADDMOD)
                         && c_reg != '0)
                begin
                    state_next = A_DIV;
                end
                else
                begin
                    state_next = A_DONE;
                end
            end
            A_MUL:
            begin
                if (mstep_reg == 6'd63)
                begin
                    state_next = (op_reg == OP_MULMOD && c_reg != '0) ? A_DIV : A_DONE;
                end
            end
            A_DIV:
            begin
                if (cnt_reg == 10'd0)
                begin
                    state_next = A_DONE;
                end
            end
            A_DONE: state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    op_reg <= req.op;
                    a_reg <= req.a;
                    b_reg <= req.b;
                    // divisor: b for DIV/MOD, c for ADDMOD/MULMOD
                    c_reg <= (req.op == OP_DIV || req.op == OP_MOD) ? req.b : req.c;
                    mstep_reg <= '0;
                    prod_reg <= '0;
                    rem_reg <= '0;
                    quo_reg <= '0;
                end
            end
            A_ADD:
            begin
                unique case (op_reg)
                    OP_ADD: res_reg <= sum257[255:0];
                    OP_SUB: res_reg <= a_reg - b_reg;
                    OP_LT: res_reg <= {255'd0, a_reg < b_reg};
                    OP_GT: res_reg <= {255'd0, b_reg < a_reg};
                    OP_EQ: res_reg <= {255'd0, a_reg == b_reg};
                    OP_ISZERO: res_reg <= {255'd0, a_reg == '0};
                    OP_AND: res_reg <= a_reg & b_reg;
                    OP_OR: res_reg <= a_reg | b_reg;
                    OP_XOR: res_reg <= a_reg ^ b_reg;
                    OP_NOT: res_reg <= ~a_reg;
                    OP_SHL: res_reg <= shl_v;
                    OP_SHR: res_reg <= shr_v;
                    default: res_reg <= '0;
                endcase
                if (op_reg == OP_ADDMOD)
                begin
                    num_reg <= {sum257, 255'd0};
                    cnt_reg <= 10'd256;
                end
                else
                begin
                    num_reg <= {a_reg, 256'd0};
                    cnt_reg <= 10'd255;
                end
            end
            A_MUL:
            begin
                prod_reg <= prod_sum;
                mstep_reg <= mstep_reg + 6'd1;
                if (mstep_reg == 6'd63)
                begin
                    res_reg <= (op_reg == OP_MUL) ? prod_sum[255:0] : '0;
                    num_reg <= prod_sum;
                    cnt_reg <= 10'd511;
                end
            end
            A_DIV:
            begin
                num_reg <= {num_reg[510:0], 1'b0};
                if (ge)
                begin
                    rem_reg <= rsub[255:0];
                end
                else
                begin
                    rem_reg <= rsh[255:0];
                end
                quo_reg <= {quo_reg[254:0], ge};
                cnt_reg <= cnt_reg - 10'd1;
                if (cnt_reg == 10'd0)
                begin
                    res_reg <= (op_reg == OP_DIV) ? {quo_reg[254:0], ge}
                             : (ge ? rsub[255:0] : rsh[255:0]);
                end
            end
            default:
            begin
                if (state_reg == A_DONE && rem_out)
                begin
                    res_reg <= '0;
                end
            end
        endcase
    end

    // remainder stays below divisor; rem_reg top bit lands in rsh[256], so rsub[256] is the borrow
    assign rsp.done = (state_reg == A_DONE);
    assign rsp.r = res_reg;
endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the 256-bit stack executor: queued stimulus, clocked driver and monitor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import smx_pkg::*;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int QUIET_LO = 30000;
    localparam int QUIET_HI = 60000;

    logic clk;
    logic rst_n;

    smx_if #(.T(instr_t)) in_if (clk);
    smx_if #(.T(logic [63:0])) cfg_if (clk);
    smx_if #(.T(result_t)) out_if (clk);

    stack_machine_256bit_executor uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_if),
        .cfg_ch(cfg_if),
        .out_ch(out_if)
    );

    instr_t  instr_q[$];
    result_t result_q[$];

    logic [255:0] stk[STACK_DEPTH];
    int unsigned  stk_ptr = 0;
    logic         is_halted = 1'b0;
    logic [2:0]   halt_status = ST_OK;
    logic [63:0]  gas_value;

    int unsigned gen_depth;
    int unsigned cycle_cnt = 0;
    int unsigned errors = 0;
    int unsigned beats_out = 0;
    logic        quiet = 1'b0;

    logic [7:0] alu_ops[] = '{OP_ADD, OP_MUL, OP_SUB, OP_DIV, OP_MOD, OP_ADDMOD, OP_MULMOD,
                               OP_LT, OP_GT, OP_EQ, OP_ISZERO, OP_AND, OP_OR, OP_XOR,
                               OP_NOT, OP_SHL, OP_SHR, OP_POP, OP_GASLIMIT, OP_PC};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void op_shape(input logic [7:0] op, output int need, output int pops,
                                     output int pushes, output logic [2:0] st);
        need = 0;
        pops = 0;
        pushes = 0;
        st = ST_OK;
        case (op)
            OP_ADD, OP_MUL, OP_SUB, OP_DIV, OP_MOD, OP_LT, OP_GT, OP_EQ, OP_AND, OP_OR,
            OP_XOR, OP_SHL, OP_SHR:
            begin
                need = 2; pops = 2; pushes = 1;
            end
            OP_ADDMOD, OP_MULMOD:
            begin
                need = 3; pops = 3; pushes = 1;
            end
            OP_ISZERO, OP_NOT:
            begin
                need = 1; pops = 1; pushes = 1;
            end
            OP_POP:
            begin
                need = 1; pops = 1;
            end
            OP_GASLIMIT, OP_PC: pushes = 1;
            OP_STOP: st = ST_STOP;
            OP_SELFD: st = ST_SELFD;
            default:
            begin
                if (op >= OP_PUSH_LO && op <= OP_PUSH_HI)
                    pushes = 1;
                else if (op >= OP_DUP_LO && op <= OP_DUP_HI)
                begin
                    need = op - OP_DUP_LO + 1; pushes = 1;
                end
                else if (op >= OP_SWAP_LO && op <= OP_SWAP_HI)
                    need = op - OP_SWAP_LO + 2;
                else
                    st = ST_INVALID;
            end
        endcase
    endfunction

    task automatic execute_instr(input instr_t it);
        int need, pops, pushes;
        logic [2:0]   st;
        logic [255:0] a, b, c, r, t, imm;
        logic [511:0] wide;
        int unsigned  bits;
        result_t      res;
        imm = {it.imm_limb3, it.imm_limb2, it.imm_limb1, it.imm_limb0};
        r = '0;
        if (is_halted)
            st = halt_status;
        else
        begin
            op_shape(it.func, need, pops, pushes, st);
            if (st == ST_OK && stk_ptr < need)
                st = ST_UNDER;
            else if (st == ST_OK && stk_ptr - pops + pushes > STACK_DEPTH)
                st = ST_OVER;
            if (st != ST_OK)
            begin
                is_halted = 1'b1;
                halt_status = st;
            end
            else
            begin
                a = (need >= 1) ? stk[stk_ptr - 1] : '0;
                b = (need >= 2) ? stk[stk_ptr - 2] : '0;
                c = (need >= 3) ? stk[stk_ptr - 3] : '0;
                case (it.func)
                    OP_ADD: r = a + b;
                    OP_MUL: r = a * b;
                    OP_SUB: r = a - b;
                    OP_DIV: r = (b == 0) ? '0 : a / b;
                    OP_MOD: r = (b == 0) ? '0 : a % b;
                    OP_ADDMOD:
                    begin
                        wide = 512'(a) + 512'(b);
                        r = (c == 0) ? '0 : 256'(wide % 512'(c));
                    end
                    OP_MULMOD:
                    begin
                        wide = 512'(a) * 512'(b);
                        r = (c == 0) ? '0 : 256'(wide % 512'(c));
                    end
                    OP_LT: r = 256'(a < b);
                    OP_GT: r = 256'(a > b);
                    OP_EQ: r = 256'(a == b);
                    OP_ISZERO: r = 256'(a == 0);
                    OP_AND: r = a & b;
                    OP_OR: r = a | b;
                    OP_XOR: r = a ^ b;
                    OP_NOT: r = ~a;
                    OP_SHL: r = (a >= 256) ? '0 : b << a[7:0];
                    OP_SHR: r = (a >= 256) ? '0 : b >> a[7:0];
                    OP_GASLIMIT: r = 256'(gas_value);
                    OP_PC: r = 256'(it.instr_addr);
                    OP_POP: r = '0;
                    default:
                    begin
                        if (it.func >= OP_PUSH_LO && it.func <= OP_PUSH_HI)
                        begin
                            bits = (it.func - OP_PUSH_LO + 1) * 8;
                            r = (bits >= 256) ? imm : imm & ((256'd1 << bits) - 1);
                        end
                        else if (it.func >= OP_DUP_LO && it.func <= OP_DUP_HI)
                            r = stk[stk_ptr - need];
                        else
                        begin
                            t = stk[stk_ptr - need];
                            stk[stk_ptr - need] = a;
                            stk[stk_ptr - 1] = t;
                        end
                    end
                endcase
                stk_ptr = stk_ptr - pops;
                if (pushes != 0)
                begin
                    stk[stk_ptr] = r;
                    stk_ptr++;
                end
            end
        end
        t = (stk_ptr > 0) ? stk[stk_ptr - 1] : '0;
        res.top_limb0 = t[63:0];
        res.top_limb1 = t[127:64];
        res.top_limb2 = t[191:128];
        res.top_limb3 = t[255:192];
        res.stack_depth = SP_W'(stk_ptr);
        res.status = st;
        result_q.push_back(res);
    endtask

    function automatic logic [255:0] rand_word();
        logic [255:0] w;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(9))
            0: w = '0;
            1: w = '1;
            2: w = 256'($urandom_range(300));
            3: w = 256'd1 << $urandom_range(255);
            4: w = w >> $urandom_range(255);
            default: ;
        endcase
        return w;
    endfunction

    task automatic add_instr(input logic [7:0] op, input logic [255:0] imm);
        instr_t it;
        int need, pops, pushes;
        logic [2:0] st;
        it.func = op;
        {it.imm_limb3, it.imm_limb2, it.imm_limb1, it.imm_limb0} = imm;
        it.instr_addr = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
        op_shape(op, need, pops, pushes, st);
        if (st == ST_OK && gen_depth >= need && gen_depth - pops + pushes <= STACK_DEPTH)
            gen_depth = gen_depth - pops + pushes;
        instr_q.push_back(it);
    endtask

    task automatic add_push(input logic [255:0] w);
        add_instr(OP_PUSH_LO + 8'($urandom_range(31)), w);
    endtask

    task automatic add_random_instr();
        logic [7:0] op;
        int need, pops, pushes;
        logic [2:0] st;
        if (gen_depth < 3 || ($urandom_range(99) < 30 && gen_depth < 40))
        begin
            add_push(rand_word());
            return;
        end
        case ($urandom_range(9))
            0: op = OP_DUP_LO + 8'($urandom_range(((gen_depth > 16) ? 16 : gen_depth) - 1));
            1: op = OP_SWAP_LO + 8'($urandom_range(((gen_depth > 17) ? 17 : gen_depth) - 2));
            2:
            begin
                add_push(256'($urandom_range(300)));
                op = ($urandom_range(1) == 0) ? OP_SHL : OP_SHR;
            end
            default: op = alu_ops[$urandom_range(alu_ops.size() - 1)];
        endcase
        op_shape(op, need, pops, pushes, st);
        if (gen_depth < need || gen_depth - pops + pushes > STACK_DEPTH - 2)
            op = OP_POP;
        add_instr(op, rand_word());
    endtask

    task automatic drain();
        while (instr_q.size() != 0 || result_q.size() != 0 || in_if.valid)
            @(posedge clk);
    endtask

    task automatic write_gas(input logic [63:0] v);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= v;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        gas_value = v;
        cfg_if.valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            in_if.valid <= 1'b0;
        else
        begin
            if (in_if.valid && in_if.ready)
            begin
                execute_instr(in_if.data);
                void'(instr_q.pop_front());
            end
            if (!(in_if.valid && !in_if.ready))
            begin
                if (instr_q.size() != 0 && (quiet || $urandom_range(99) >= 27))
                begin
                    in_if.valid <= 1'b1;
                    in_if.data <= instr_q[0];
                end
                else
                    in_if.valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t e;
        if (!rst_n)
            out_if.ready <= 1'b0;
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                beats_out++;
                if (result_q.size() == 0)
                begin
                    $error("result beat with no expectation pending");
                    errors++;
                end
                else
                begin
                    e = result_q.pop_front();
                    check_field("top_limb0", e.top_limb0, out_if.data.top_limb0);
                    check_field("top_limb1", e.top_limb1, out_if.data.top_limb1);
                    check_field("top_limb2", e.top_limb2, out_if.data.top_limb2);
                    check_field("top_limb3", e.top_limb3, out_if.data.top_limb3);
                    check_field("stack_depth", 64'(e.stack_depth), 64'(out_if.data.stack_depth));
                    check_field("status", 64'(e.status), 64'(out_if.data.status));
                end
            end
            out_if.ready <= quiet || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        quiet <= (cycle_cnt >= QUIET_LO && cycle_cnt < QUIET_HI);
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] gas_set[3];
        int kind;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        gas_value = GAS_RESET;
        gen_depth = 0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, truncation, zero divisors, large shifts, deep dup/swap
        add_instr(OP_PUSH_HI, '1);
        add_instr(OP_PUSH_LO, '1);
        add_instr(OP_ADD, '0);
        add_instr(OP_PUSH_LO + 8'd15, '1);
        add_instr(OP_PUSH_LO + 8'd2, '0);
        add_instr(OP_DIV, '0);
        add_instr(OP_PUSH_LO, '0);
        add_instr(OP_PUSH_HI, '1);
        add_instr(OP_MOD, '0);
        add_instr(OP_PUSH_LO, '0);
        add_instr(OP_PUSH_HI, '1);
        add_instr(OP_PUSH_HI, '1);
        add_instr(OP_MULMOD, '0);
        add_instr(OP_PUSH_HI, 256'd7);
        add_instr(OP_PUSH_HI, '1);
        add_instr(OP_PUSH_HI, '1);
        add_instr(OP_ADDMOD, '0);
        add_instr(OP_PUSH_HI, '1);
        add_instr(OP_PUSH_LO + 8'd1, 256'd256);
        add_instr(OP_SHL, '0);
        add_instr(OP_GASLIMIT, '0);
        add_instr(OP_PC, '0);
        repeat (8) add_push(rand_word());
        add_instr(OP_DUP_HI, '0);
        add_instr(OP_SWAP_HI, '0);

        kind = $urandom_range(5);
        gas_set = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, {$urandom, $urandom}};
        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                write_gas(gas_set[ph - 1]);
            end
            repeat ((kind == 5) ? 220 : 470) add_random_instr();
        end
        drain();

        case (kind)
            0: add_instr(OP_STOP, '0);
            1: add_instr(OP_SELFD, '0);
            2: add_instr(8'hFE, '0);
            3: add_instr(8'h51 + 8'($urandom_range(5)), '0);
            4:
            begin
                while (gen_depth > 0)
                    add_instr(OP_POP, '0);
                add_instr(OP_ADDMOD, '0);
            end
            default:
            begin
                while (gen_depth < STACK_DEPTH)
                    add_push(rand_word());
                add_push(rand_word());
            end
        endcase
        repeat (12)
            add_instr(8'($urandom), rand_word());
        drain();
        repeat (600) @(posedge clk);

        $display("ran %0d instructions over 4 gas limit settings, ending in halt case %0d",
                 beats_out, kind);
        $display("%0d cycles, %0d errors", cycle_cnt, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- sim.f -----
src/smx_pkg.sv
src/smx_if.sv
src/smx_ram.sv
src/smx_alu.sv
src/stack_machine_256bit_executor.sv
sim/testbench.sv
